[hdl/assert_macros.svh]
// Assertion macros shared by the statistics monitor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define MSM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("msm assertion failed");

// Condition must never be seen outside reset
`define MSM_NEVER(lbl, clk, rst, cond) \
  `MSM_ASSERT(lbl, clk, rst, !(cond))

`endif

[hdl/msm_pkg.sv]
// Shared types, constants and saturating helpers for the statistics monitor
package msm_pkg;

  localparam int NUM_TYPES_DEF = 9;
  localparam int QUEUE_DEPTH   = 2;
  localparam int TYPE_W        = 4;
  localparam int BYTES_W       = 40;
  localparam int CNT_W         = 32;
  localparam int TOT_W         = 48;

  typedef enum logic [1:0] {
    OP_SUCCESS = 2'd0,
    OP_FAILURE = 2'd1,
    OP_FREE    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // classified event passed from the front end to the update engine
  typedef struct packed {
    op_t                op;
    logic [TYPE_W-1:0]  rq;
    logic [TYPE_W-1:0]  ac;
    logic [BYTES_W-1:0] nb;
    logic               rq_ok;
    logic               ac_ok;
  } item_t;

  // counters indexed by the requested type
  typedef struct packed {
    logic [CNT_W-1:0] attempts;
    logic [CNT_W-1:0] failures;
    logic [CNT_W-1:0] fb_from;
  } row_rq_t;

  // counters and byte totals indexed by the actual type
  typedef struct packed {
    logic [CNT_W-1:0] successes;
    logic [CNT_W-1:0] frees;
    logic [CNT_W-1:0] fb_to;
    logic [TOT_W-1:0] live;
    logic [TOT_W-1:0] peak;
    logic [TOT_W-1:0] alloc;
    logic [TOT_W-1:0] freed;
  } row_ac_t;

  function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
    bump_sat = (&v) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [TOT_W-1:0] add_sat(input logic [TOT_W-1:0] v,
                                               input logic [TOT_W-1:0] a);
    logic [TOT_W:0] s;
    s = {1'b0, v} + {1'b0, a};
    add_sat = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

[hdl/msm_front.sv]
// Front end: takes input beats, checks type codes and pushes them to the queue
module msm_front
  import msm_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [TYPE_W-1:0]  requested_code,
  input  logic [TYPE_W-1:0]  actual_code,
  input  logic [BYTES_W-1:0] byte_count,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  // one spare bit so that sixteen types still compare correctly
  localparam logic [TYPE_W:0] TYPE_LIMIT = (TYPE_W+1)'(NUM_TYPES);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.op    = op_t'(opcode);
    q_item.rq    = requested_code;
    q_item.ac    = actual_code;
    q_item.nb    = byte_count;
    q_item.rq_ok = {1'b0, requested_code} < TYPE_LIMIT;
    q_item.ac_ok = {1'b0, actual_code} < TYPE_LIMIT;
  end

endmodule

[hdl/msm_fifo.sv]
// Short event queue between the front end and the update engine
`include "assert_macros.svh"
module msm_fifo
  import msm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

  item_t                slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W_Q-1:0]   count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W_Q'(1);
      end
    end
  end

  `MSM_NEVER(a_no_overflow, clk, rst, push && full && !pop)
  `MSM_NEVER(a_no_underflow, clk, rst, pop && !not_empty)

endmodule

[hdl/msm_back.sv]
// Update engine: per-type statistics tables, read-modify-write and read results
`include "assert_macros.svh"
module msm_back
  import msm_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             type_valid,
  output logic [CNT_W-1:0] attempts,
  output logic [CNT_W-1:0] failures,
  output logic [CNT_W-1:0] successes,
  output logic [CNT_W-1:0] free_events,
  output logic [TOT_W-1:0] live_bytes,
  output logic [TOT_W-1:0] peak_live_bytes,
  output logic [TOT_W-1:0] allocated_total,
  output logic [TOT_W-1:0] freed_total,
  output logic [CNT_W-1:0] fell_back_from,
  output logic [CNT_W-1:0] fell_back_to,
  output logic [CNT_W-1:0] bad_type_events
);

  localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXE  = 2'b10
  } state_t;

  state_t state;
  item_t  cur;

  // two tables, one read port each, so one event touches both rows in a pass
  row_rq_t mem_rq [NUM_TYPES];
  row_ac_t mem_ac [NUM_TYPES];
  logic [NUM_TYPES-1:0] vld_rq;
  logic [NUM_TYPES-1:0] vld_ac;
  row_rq_t rd_rq;
  row_ac_t rd_ac;

  logic [CNT_W-1:0] inv_count;

  logic [IDX_W-1:0] rq_addr;
  logic [IDX_W-1:0] ac_addr;
  logic [IDX_W-1:0] rq_idx;
  logic [IDX_W-1:0] ac_idx;
  logic             ac_sel_ok;

  logic             proceed;
  logic             wr_rq;
  logic             wr_ac;
  logic             fallback;
  row_rq_t          rq_next;
  row_ac_t          ac_next;
  logic [TOT_W-1:0] nb_wide;
  logic [TOT_W-1:0] live_add;
  logic [TOT_W-1:0] release_bytes;
  logic [1:0]       bad_inc;
  logic [CNT_W:0]   inv_sum;
  logic [CNT_W-1:0] inv_count_next;

  // read addresses for the entry leaving the queue; a read uses the requested type
  always_comb begin
    ac_sel_ok = (q_item.op == OP_READ) ? q_item.rq_ok : q_item.ac_ok;
    rq_addr   = q_item.rq_ok ? q_item.rq[IDX_W-1:0] : '0;
    if (!ac_sel_ok) begin
      ac_addr = '0;
    end else if (q_item.op == OP_READ) begin
      ac_addr = q_item.rq[IDX_W-1:0];
    end else begin
      ac_addr = q_item.ac[IDX_W-1:0];
    end
  end

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign proceed = (state == ST_EXE) &&
                   ((cur.op != OP_READ) || !out_valid || out_ready);
  assign rq_idx  = cur.rq[IDX_W-1:0];
  assign ac_idx  = cur.ac[IDX_W-1:0];

  always_comb begin
    fallback = cur.rq_ok && cur.ac_ok && (cur.rq != cur.ac);
    nb_wide  = {{(TOT_W-BYTES_W){1'b0}}, cur.nb};
    live_add = add_sat(rd_ac.live, nb_wide);
    release_bytes = (nb_wide > rd_ac.live) ? rd_ac.live : nb_wide;

    wr_rq   = 1'b0;
    wr_ac   = 1'b0;
    rq_next = rd_rq;
    ac_next = rd_ac;
    bad_inc = 2'd0;

    case (cur.op)
      OP_SUCCESS: begin
        wr_rq = cur.rq_ok;
        wr_ac = cur.ac_ok;
        rq_next.attempts = bump_sat(rd_rq.attempts);
        if (fallback) begin
          rq_next.fb_from = bump_sat(rd_rq.fb_from);
          ac_next.fb_to   = bump_sat(rd_ac.fb_to);
        end
        ac_next.successes = bump_sat(rd_ac.successes);
        ac_next.live      = live_add;
        ac_next.alloc     = add_sat(rd_ac.alloc, nb_wide);
        ac_next.peak      = (live_add > rd_ac.peak) ? live_add : rd_ac.peak;
        bad_inc = 2'({1'b0, !cur.rq_ok} + {1'b0, !cur.ac_ok});
      end
      OP_FAILURE: begin
        wr_rq = cur.rq_ok;
        rq_next.attempts = bump_sat(rd_rq.attempts);
        rq_next.failures = bump_sat(rd_rq.failures);
        bad_inc = {1'b0, !cur.rq_ok};
      end
      OP_FREE: begin
        wr_ac = cur.ac_ok;
        ac_next.frees = bump_sat(rd_ac.frees);
        ac_next.live  = rd_ac.live - release_bytes;
        ac_next.freed = add_sat(rd_ac.freed, release_bytes);
        bad_inc = {1'b0, !cur.ac_ok};
      end
      default: begin
      end
    endcase

    inv_sum        = {1'b0, inv_count} + (CNT_W+1)'(bad_inc);
    inv_count_next = inv_sum[CNT_W] ? {CNT_W{1'b1}} : inv_sum[CNT_W-1:0];
  end

  // table storage and registered reads; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_rq <= vld_rq[rq_addr] ? mem_rq[rq_addr] : '0;
      rd_ac <= vld_ac[ac_addr] ? mem_ac[ac_addr] : '0;
      cur   <= q_item;
    end
    if (proceed && wr_rq) begin
      mem_rq[rq_idx] <= rq_next;
    end
    if (proceed && wr_ac) begin
      mem_ac[ac_idx] <= ac_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && (cur.op == OP_READ)) begin
      type_valid      <= cur.rq_ok;
      attempts        <= cur.rq_ok ? rd_rq.attempts : '0;
      failures        <= cur.rq_ok ? rd_rq.failures : '0;
      fell_back_from  <= cur.rq_ok ? rd_rq.fb_from  : '0;
      successes       <= cur.rq_ok ? rd_ac.successes : '0;
      free_events     <= cur.rq_ok ? rd_ac.frees    : '0;
      fell_back_to    <= cur.rq_ok ? rd_ac.fb_to    : '0;
      live_bytes      <= cur.rq_ok ? rd_ac.live     : '0;
      peak_live_bytes <= cur.rq_ok ? rd_ac.peak     : '0;
      allocated_total <= cur.rq_ok ? rd_ac.alloc    : '0;
      freed_total     <= cur.rq_ok ? rd_ac.freed    : '0;
      bad_type_events <= inv_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld_rq    <= '0;
      vld_ac    <= '0;
      inv_count <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_EXE;
          end
        end
        ST_EXE: begin
          if (proceed) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (proceed && wr_rq) begin
        vld_rq[rq_idx] <= 1'b1;
      end
      if (proceed && wr_ac) begin
        vld_ac[ac_idx] <= 1'b1;
      end
      if (proceed) begin
        inv_count <= inv_count_next;
      end
      if (proceed && (cur.op == OP_READ)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MSM_ASSERT(a_result_from_exe, clk, rst,
              $rose(out_valid) |-> ($past(state) == ST_EXE))
  `MSM_ASSERT(a_bad_count_monotone, clk, rst,
              !$past(rst) |-> (inv_count >= $past(inv_count)))

endmodule

[hdl/memory_allocation_stats_monitor.sv]
// Top level of the memory allocation statistics monitor
//
// Keeps saturating allocation statistics for NUM_TYPES memory type codes and
// returns one type's row for each read event; success, failure and free events
// give no result. Input beats enter a two-entry queue through a front end that
// checks the type codes; the input drops ready only while both queue entries
// are taken, that is when the engine falls behind or a result waits. The
// update engine handles one event at a time: in ST_IDLE it pops the event and
// reads the requested-type and actual-type rows from their two tables, and in
// ST_EXE it updates and writes them back before it pops the next event. A read
// result holds in the output register until taken; the engine stalls only when
// a second read completes before the first is taken. All tables read as zero
// after reset without any clearing pass.
module memory_allocation_stats_monitor
  import msm_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [TYPE_W-1:0]  requested_code,
  input  logic [TYPE_W-1:0]  actual_code,
  input  logic [BYTES_W-1:0] byte_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               type_valid,
  output logic [CNT_W-1:0]   attempts,
  output logic [CNT_W-1:0]   failures,
  output logic [CNT_W-1:0]   successes,
  output logic [CNT_W-1:0]   free_events,
  output logic [TOT_W-1:0]   live_bytes,
  output logic [TOT_W-1:0]   peak_live_bytes,
  output logic [TOT_W-1:0]   allocated_total,
  output logic [TOT_W-1:0]   freed_total,
  output logic [CNT_W-1:0]   fell_back_from,
  output logic [CNT_W-1:0]   fell_back_to,
  output logic [CNT_W-1:0]   bad_type_events
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t push_item;
  item_t pop_item;

  msm_front #(
    .NUM_TYPES(NUM_TYPES)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .requested_code (requested_code),
    .actual_code    (actual_code),
    .byte_count     (byte_count),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  msm_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  msm_back #(
    .NUM_TYPES(NUM_TYPES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_not_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .type_valid      (type_valid),
    .attempts        (attempts),
    .failures        (failures),
    .successes       (successes),
    .free_events     (free_events),
    .live_bytes      (live_bytes),
    .peak_live_bytes (peak_live_bytes),
    .allocated_total (allocated_total),
    .freed_total     (freed_total),
    .fell_back_from  (fell_back_from),
    .fell_back_to    (fell_back_to),
    .bad_type_events (bad_type_events)
  );

endmodule

[bench/msm_stats_checker.sv]
// Checker for the statistics monitor: watches both channels, predicts readouts and compares
`timescale 1ns / 1ps

module msm_stats_checker
  import msm_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [TYPE_W-1:0]  requested_code,
  input  logic [TYPE_W-1:0]  actual_code,
  input  logic [BYTES_W-1:0] byte_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               type_valid,
  input  logic [CNT_W-1:0]   attempts,
  input  logic [CNT_W-1:0]   failures,
  input  logic [CNT_W-1:0]   successes,
  input  logic [CNT_W-1:0]   free_events,
  input  logic [TOT_W-1:0]   live_bytes,
  input  logic [TOT_W-1:0]   peak_live_bytes,
  input  logic [TOT_W-1:0]   allocated_total,
  input  logic [TOT_W-1:0]   freed_total,
  input  logic [CNT_W-1:0]   fell_back_from,
  input  logic [CNT_W-1:0]   fell_back_to,
  input  logic [CNT_W-1:0]   bad_type_events,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef struct packed {
    logic             valid_type;
    logic [CNT_W-1:0] attempts;
    logic [CNT_W-1:0] failures;
    logic [CNT_W-1:0] successes;
    logic [CNT_W-1:0] frees;
    logic [TOT_W-1:0] live;
    logic [TOT_W-1:0] peak;
    logic [TOT_W-1:0] alloc;
    logic [TOT_W-1:0] freed;
    logic [CNT_W-1:0] fb_from;
    logic [CNT_W-1:0] fb_to;
    logic [CNT_W-1:0] bad;
  } stats_readout_t;

  // mirrored statistics table
  logic [CNT_W-1:0] attempt_tally  [NUM_TYPES];
  logic [CNT_W-1:0] failure_tally  [NUM_TYPES];
  logic [CNT_W-1:0] success_tally  [NUM_TYPES];
  logic [CNT_W-1:0] free_tally     [NUM_TYPES];
  logic [CNT_W-1:0] fb_from_tally  [NUM_TYPES];
  logic [CNT_W-1:0] fb_to_tally    [NUM_TYPES];
  logic [TOT_W-1:0] live_sum       [NUM_TYPES];
  logic [TOT_W-1:0] peak_sum       [NUM_TYPES];
  logic [TOT_W-1:0] alloc_sum      [NUM_TYPES];
  logic [TOT_W-1:0] freed_sum      [NUM_TYPES];
  logic [CNT_W-1:0] bad_type_tally;

  stats_readout_t expected_readouts[$];

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] v,
                                               input logic [TOT_W-1:0] a);
    return (a > TOT_MAX - v) ? TOT_MAX : v + a;
  endfunction

  task automatic clear_table();
    for (int t = 0; t < NUM_TYPES; t++) begin
      attempt_tally[t] = '0;
      failure_tally[t] = '0;
      success_tally[t] = '0;
      free_tally[t]    = '0;
      fb_from_tally[t] = '0;
      fb_to_tally[t]   = '0;
      live_sum[t]      = '0;
      peak_sum[t]      = '0;
      alloc_sum[t]     = '0;
      freed_sum[t]     = '0;
    end
    bad_type_tally = '0;
  endtask

  task automatic apply_event(input op_t op, input logic [TYPE_W-1:0] rq,
                             input logic [TYPE_W-1:0] ac, input logic [BYTES_W-1:0] nb);
    stats_readout_t   r;
    logic             rq_ok;
    logic             ac_ok;
    logic [TOT_W-1:0] released;
    rq_ok = int'(rq) < NUM_TYPES;
    ac_ok = int'(ac) < NUM_TYPES;
    case (op)
      OP_SUCCESS: begin
        if (rq_ok) attempt_tally[rq] = sat_inc(attempt_tally[rq]);
        else bad_type_tally = sat_inc(bad_type_tally);
        if (!ac_ok) begin
          bad_type_tally = sat_inc(bad_type_tally);
        end else begin
          success_tally[ac] = sat_inc(success_tally[ac]);
          live_sum[ac]      = sat_add(live_sum[ac], TOT_W'(nb));
          alloc_sum[ac]     = sat_add(alloc_sum[ac], TOT_W'(nb));
          if (live_sum[ac] > peak_sum[ac]) peak_sum[ac] = live_sum[ac];
          // fallback only when the requested code is itself a real type
          if (rq_ok && rq != ac) begin
            fb_from_tally[rq] = sat_inc(fb_from_tally[rq]);
            fb_to_tally[ac]   = sat_inc(fb_to_tally[ac]);
          end
        end
      end
      OP_FAILURE: begin
        if (!rq_ok) begin
          bad_type_tally = sat_inc(bad_type_tally);
        end else begin
          attempt_tally[rq] = sat_inc(attempt_tally[rq]);
          failure_tally[rq] = sat_inc(failure_tally[rq]);
        end
      end
      OP_FREE: begin
        if (!ac_ok) begin
          bad_type_tally = sat_inc(bad_type_tally);
        end else begin
          // release no more than is currently held
          released       = (TOT_W'(nb) > live_sum[ac]) ? live_sum[ac] : TOT_W'(nb);
          free_tally[ac] = sat_inc(free_tally[ac]);
          live_sum[ac]   = live_sum[ac] - released;
          freed_sum[ac]  = sat_add(freed_sum[ac], released);
        end
      end
      default: begin
        r = '0;
        if (rq_ok) begin
          r.valid_type = 1'b1;
          r.attempts   = attempt_tally[rq];
          r.failures   = failure_tally[rq];
          r.successes  = success_tally[rq];
          r.frees      = free_tally[rq];
          r.live       = live_sum[rq];
          r.peak       = peak_sum[rq];
          r.alloc      = alloc_sum[rq];
          r.freed      = freed_sum[rq];
          r.fb_from    = fb_from_tally[rq];
          r.fb_to      = fb_to_tally[rq];
        end
        r.bad = bad_type_tally;
        expected_readouts.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stats_readout_t e;
    if (rst) begin
      clear_table();
      expected_readouts.delete();
    end else begin
      if (in_valid && in_ready)
        apply_event(op_t'(opcode), requested_code, actual_code, byte_count);
      if (out_valid && out_ready) begin
        if (expected_readouts.size() == 0) begin
          $error("readout beat with nothing outstanding");
          fail_count++;
        end else begin
          e = expected_readouts.pop_front();
          check_field("type_valid", 64'(e.valid_type), 64'(type_valid));
          check_field("attempts", 64'(e.attempts), 64'(attempts));
          check_field("failures", 64'(e.failures), 64'(failures));
          check_field("successes", 64'(e.successes), 64'(successes));
          check_field("free_events", 64'(e.frees), 64'(free_events));
          check_field("live_bytes", 64'(e.live), 64'(live_bytes));
          check_field("peak_live_bytes", 64'(e.peak), 64'(peak_live_bytes));
          check_field("allocated_total", 64'(e.alloc), 64'(allocated_total));
          check_field("freed_total", 64'(e.freed), 64'(freed_total));
          check_field("fell_back_from", 64'(e.fb_from), 64'(fell_back_from));
          check_field("fell_back_to", 64'(e.fb_to), 64'(fell_back_to));
          check_field("bad_type_events", 64'(e.bad), 64'(bad_type_events));
        end
      end
    end
    pending = expected_readouts.size();
  end

endmodule

[bench/tb_memory_allocation_stats_monitor.sv]
// Testbench top for the statistics monitor: clock, reset, event stimulus and verdict
`timescale 1ns / 1ps

module tb_memory_allocation_stats_monitor;
  import msm_pkg::*;

  localparam logic [BYTES_W-1:0] MAX_BYTES   = '1;
  localparam int                 HOLD_CYCLES = 300;
  localparam int                 DRAIN_LIMIT = 20000;
  localparam int                 TAIL_CYCLES = 12;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic [TYPE_W-1:0]  requested_code;
  logic [TYPE_W-1:0]  actual_code;
  logic [BYTES_W-1:0] byte_count;
  logic               out_valid;
  logic               out_ready;
  logic               type_valid;
  logic [CNT_W-1:0]   attempts;
  logic [CNT_W-1:0]   failures;
  logic [CNT_W-1:0]   successes;
  logic [CNT_W-1:0]   free_events;
  logic [TOT_W-1:0]   live_bytes;
  logic [TOT_W-1:0]   peak_live_bytes;
  logic [TOT_W-1:0]   allocated_total;
  logic [TOT_W-1:0]   freed_total;
  logic [CNT_W-1:0]   fell_back_from;
  logic [CNT_W-1:0]   fell_back_to;
  logic [CNT_W-1:0]   bad_type_events;

  int fail_count;
  int pending;
  bit quiet;        // no gaps on either side while set
  int hold_tokens;  // long receiver hold-offs asked for
  int hold_served;  // long receiver hold-offs started

  memory_allocation_stats_monitor dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .requested_code  (requested_code),
    .actual_code     (actual_code),
    .byte_count      (byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .type_valid      (type_valid),
    .attempts        (attempts),
    .failures        (failures),
    .successes       (successes),
    .free_events     (free_events),
    .live_bytes      (live_bytes),
    .peak_live_bytes (peak_live_bytes),
    .allocated_total (allocated_total),
    .freed_total     (freed_total),
    .fell_back_from  (fell_back_from),
    .fell_back_to    (fell_back_to),
    .bad_type_events (bad_type_events)
  );

  msm_stats_checker u_stats_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .requested_code  (requested_code),
    .actual_code     (actual_code),
    .byte_count      (byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .type_valid      (type_valid),
    .attempts        (attempts),
    .failures        (failures),
    .successes       (successes),
    .free_events     (free_events),
    .live_bytes      (live_bytes),
    .peak_live_bytes (peak_live_bytes),
    .allocated_total (allocated_total),
    .freed_total     (freed_total),
    .fell_back_from  (fell_back_from),
    .fell_back_to    (fell_back_to),
    .bad_type_events (bad_type_events),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TYPE_W-1:0] rand_type();
    if ($urandom_range(0, 4) == 0) return TYPE_W'($urandom_range(0, 15));
    return TYPE_W'($urandom_range(0, NUM_TYPES_DEF - 1));
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MAX_BYTES;
      2, 3, 4: return BYTES_W'($urandom_range(0, 4096));
      default: return BYTES_W'({$urandom, $urandom});
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_event(input op_t op, input logic [TYPE_W-1:0] rq,
                            input logic [TYPE_W-1:0] ac, input logic [BYTES_W-1:0] nb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode         <= op;
    requested_code <= rq;
    actual_code    <= ac;
    byte_count     <= nb;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
  endtask

  // receiver
  initial begin
    int gap;
    out_ready   = 1'b0;
    hold_served = 0;
    @(negedge clk);
    forever begin
      if (hold_served != hold_tokens) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // sender and verdict
  initial begin
    op_t              op;
    logic [TYPE_W-1:0] rq;
    int               r;
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = OP_READ;
    requested_code = '0;
    actual_code    = '0;
    byte_count     = '0;
    quiet          = 1'b0;
    hold_tokens    = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty rows, every operation, invalid codes, clamping
    send_event(OP_READ, 4'd0, 4'd15, MAX_BYTES);
    send_event(OP_READ, 4'd15, 4'd0, '0);
    send_event(OP_READ, 4'd9, 4'd3, '0);
    send_event(OP_SUCCESS, 4'd0, 4'd0, MAX_BYTES);
    send_event(OP_SUCCESS, 4'd1, 4'd2, '0);
    send_event(OP_SUCCESS, 4'd12, 4'd3, 40'd5);
    send_event(OP_SUCCESS, 4'd4, 4'd15, 40'd77);
    send_event(OP_SUCCESS, 4'd15, 4'd9, 40'd9);
    send_event(OP_FAILURE, 4'd8, 4'd15, MAX_BYTES);
    send_event(OP_FAILURE, 4'd10, 4'd1, 40'd3);
    send_event(OP_FREE, 4'd15, 4'd0, 40'd100);
    send_event(OP_FREE, 4'd6, 4'd2, MAX_BYTES);
    send_event(OP_FREE, 4'd0, 4'd0, MAX_BYTES);
    send_event(OP_FREE, 4'd2, 4'd11, 40'd1);
    send_event(OP_READ, 4'd0, 4'd0, '0);
    send_event(OP_READ, 4'd1, 4'd0, '0);
    send_event(OP_READ, 4'd2, 4'd0, '0);
    send_event(OP_READ, 4'd3, 4'd0, '0);
    send_event(OP_READ, 4'd4, 4'd0, '0);
    send_event(OP_READ, 4'd8, 4'd0, '0);
    send_event(OP_READ, 4'd12, 4'd0, '0);

    // sender stops until every readout is back
    in_valid <= 1'b0;
    wait_drained();

    // drive type 8 live and allocated bytes into saturation
    for (int i = 0; i < 270; i++) begin
      rq = ($urandom_range(0, 3) == 0) ? rand_type() : 4'd8;
      send_event(OP_SUCCESS, rq, 4'd8, MAX_BYTES - BYTES_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) send_event(OP_READ, 4'd8, rand_type(), rand_bytes());
    end
    send_event(OP_READ, 4'd8, 4'd0, '0);
    // peak must stay pinned while live drops and climbs again
    for (int i = 0; i < 4; i++) begin
      send_event(OP_FREE, rand_type(), 4'd8, MAX_BYTES);
      send_event(OP_READ, 4'd8, 4'd0, '0);
    end
    send_event(OP_SUCCESS, 4'd8, 4'd8, MAX_BYTES);
    send_event(OP_READ, 4'd8, 4'd0, '0);

    // alternate alloc/free on type 7 until the freed total saturates
    for (int i = 0; i < 270; i++) begin
      send_event(OP_SUCCESS, rand_type(), 4'd7, MAX_BYTES - BYTES_W'($urandom_range(0, 15)));
      send_event(OP_FREE, rand_type(), 4'd7, MAX_BYTES);
      if ($urandom_range(0, 15) == 0) send_event(OP_READ, 4'd7, rand_type(), rand_bytes());
    end
    send_event(OP_READ, 4'd7, 4'd0, '0);

    // long receiver hold-off while reads keep coming, so the input backs up
    hold_tokens++;
    while (hold_served != hold_tokens) @(negedge clk);
    quiet = 1'b1;
    for (int i = 0; i < 24; i++) send_event(OP_READ, rand_type(), rand_type(), rand_bytes());
    quiet = 1'b0;

    for (int i = 0; i < 620; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_SUCCESS;
      else if (r < 55) op = OP_FAILURE;
      else if (r < 80) op = OP_FREE;
      else op = OP_READ;
      send_event(op, rand_type(), rand_type(), rand_bytes());
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit: a run still going at this time is reported as a failure
  initial begin
    #10000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/msm_pkg.sv
hdl/msm_front.sv
hdl/msm_fifo.sv
hdl/msm_back.sv
hdl/memory_allocation_stats_monitor.sv
bench/msm_stats_checker.sv
bench/tb_memory_allocation_stats_monitor.sv
